>>> design/tleb_pkg.sv
// Shared types, constants and the escape sequence table of the line edit buffer.
package tleb_pkg;

    localparam int POS_W        = 6;
    localparam int CHAR_W       = 64;
    localparam int RESULT_LIMIT = 32;

    localparam logic [7:0] ESC_BYTE   = 8'd27;
    localparam logic [7:0] ENTER_BYTE = 8'd13;
    localparam logic [7:0] BS_BYTE    = 8'd127;
    localparam logic [7:0] PRINT_MIN  = 8'd31;

    localparam logic [4:0] KEY_NONE  = 5'd0;
    localparam logic [4:0] KEY_ESC   = 5'd1;
    localparam logic [4:0] KEY_LEFT  = 5'd16;
    localparam logic [4:0] KEY_RIGHT = 5'd17;
    localparam logic [4:0] KEY_DEL   = 5'd19;

    localparam logic [1:0] ST_EDIT   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_CANCEL = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [POS_W-1:0] pos;
    } t_cell_ctrl;

    function automatic logic [4:0] match_key(input logic [CHAR_W-1:0] seq);
        logic [4:0] key;
        unique case (seq)
            64'h0000_0000_0000_001B: key = 5'd1;
            64'h0000_0000_0050_4F1B: key = 5'd2;
            64'h0000_0000_0051_4F1B: key = 5'd3;
            64'h0000_0000_0052_4F1B: key = 5'd4;
            64'h0000_0000_0053_4F1B: key = 5'd5;
            64'h0000_007E_3531_5B1B: key = 5'd6;
            64'h0000_007E_3731_5B1B: key = 5'd7;
            64'h0000_007E_3831_5B1B: key = 5'd8;
            64'h0000_007E_3931_5B1B: key = 5'd9;
            64'h0000_007E_3032_5B1B: key = 5'd10;
            64'h0000_007E_3132_5B1B: key = 5'd11;
            64'h0000_007E_3332_5B1B: key = 5'd12;
            64'h0000_007E_3432_5B1B: key = 5'd13;
            64'h0000_0000_0041_5B1B: key = 5'd14;
            64'h0000_0000_0042_5B1B: key = 5'd15;
            64'h0000_0000_0044_5B1B: key = 5'd16;
            64'h0000_0000_0043_5B1B: key = 5'd17;
            64'h0000_0000_7E32_5B1B: key = 5'd18;
            64'h0000_0000_7E33_5B1B: key = 5'd19;
            64'h0000_0000_7E37_5B1B: key = 5'd20;
            64'h0000_0000_7E38_5B1B: key = 5'd21;
            64'h0000_0000_7E35_5B1B: key = 5'd22;
            64'h0000_0000_7E36_5B1B: key = 5'd23;
            64'h0000_0000_415B_5B1B: key = 5'd2;
            64'h0000_0000_425B_5B1B: key = 5'd3;
            64'h0000_0000_435B_5B1B: key = 5'd4;
            64'h0000_0000_445B_5B1B: key = 5'd5;
            64'h0000_0000_455B_5B1B: key = 5'd6;
            64'h0000_0000_7E31_5B1B: key = 5'd20;
            64'h0000_0000_7E34_5B1B: key = 5'd21;
            default:                 key = KEY_NONE;
        endcase
        return key;
    endfunction

endpackage

>>> design/tleb_cell.sv
// One character slot of the line, taking a neighbor's word on insert, remove or shift.
module tleb_cell import tleb_pkg::*; #(
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [CHAR_W-1:0] i_left,
    input  logic [CHAR_W-1:0] i_right,
    input  logic [CHAR_W-1:0] i_char,
    output logic [CHAR_W-1:0] o_slot
);

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    logic [CHAR_W-1:0] r_slot;
    logic [CHAR_W-1:0] n_slot;

    always_comb begin
        n_slot = r_slot;
        unique case (i_ctrl.op)
            OP_HOLD: begin
                n_slot = r_slot;
            end
            OP_INSERT: begin
                if (IDX > i_ctrl.pos) begin
                    n_slot = i_left;
                end else if (IDX == i_ctrl.pos) begin
                    n_slot = i_char;
                end
            end
            OP_REMOVE: begin
                if (IDX >= i_ctrl.pos) begin
                    n_slot = i_right;
                end
            end
            OP_SHIFT: begin
                n_slot = i_right;
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

>>> design/terminal_line_edit_buffer_core.sv
// Top level of the line edit buffer: key decode, line control and the row of slot cells.
// An edit or cancel word is captured, then decoded in S_DECODE, which registers its one result.
// Enter, once decoded, gives its characters from S_EMIT, one per cycle.
// The block takes a new word only when idle (busy low); Enter stays busy while its
// characters leave, the slot row shifting one word toward slot zero each cycle.
// Reset clears the line, the cursor and sets the width register for a width of 32; results cannot stall.
module terminal_line_edit_buffer_core import tleb_pkg::*; #(
    parameter int MAX_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_byte_0,
    input  logic [7:0]  i_byte_1,
    input  logic [7:0]  i_byte_2,
    input  logic [7:0]  i_byte_3,
    input  logic [7:0]  i_byte_4,
    input  logic [7:0]  i_byte_5,
    input  logic [7:0]  i_byte_6,
    input  logic [7:0]  i_byte_7,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_line_width,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [4:0]  o_key_id,
    output logic [4:0]  o_cursor_pos,
    output logic [4:0]  o_line_length,
    output logic [63:0] o_char_data,
    output logic        o_last
);

    localparam int LW = $clog2(MAX_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [CHAR_W-1:0] r_bytes;
    logic [LW-1:0]     r_held;
    logic [LW-1:0]     r_cursor;
    logic [LW-1:0]     r_wm1;
    logic [5:0]        r_count;
    logic              r_strobe;
    logic [1:0]        r_status;
    logic [4:0]        r_key;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    logic [CHAR_W-1:0] w_cut;
    logic              w_esc_seen;
    logic [4:0]        w_key;
    logic [7:0]        w_b0;
    logic              w_is_esc;
    logic              w_is_enter;
    logic              w_is_bs;
    logic              w_insert;
    logic [LW:0]       w_held_p1;
    logic [LW:0]       w_wm1_ext;
    logic [LW-1:0]     w_newlen;
    logic [5:0]        w_n;
    t_cell_ctrl        w_ctrl;

    logic [CHAR_W-1:0] w_slot  [MAX_WIDTH];
    logic [CHAR_W-1:0] w_left  [MAX_WIDTH];
    logic [CHAR_W-1:0] w_right [MAX_WIDTH];

    function automatic logic [LW-1:0] f_wm1(input logic [5:0] lw);
        logic [6:0] v;
        v = {1'b0, lw};
        if (v < 7'd2) begin
            return LW'(1);
        end else if (v > 7'(MAX_WIDTH)) begin
            return LW'(MAX_WIDTH - 1);
        end
        return LW'(v - 7'd1);
    endfunction

    always_comb begin
        w_esc_seen  = 1'b0;
        w_cut       = r_bytes;
        for (int i = 1; i < 8; i++) begin
            if (r_bytes[8*i +: 8] == ESC_BYTE) begin
                w_esc_seen = 1'b1;
            end
            if (w_esc_seen) begin
                w_cut[8*i +: 8] = 8'd0;
            end
        end
    end

    assign w_b0       = r_bytes[7:0];
    assign w_is_esc   = (w_b0 == ESC_BYTE);
    assign w_is_enter = (w_b0 == ENTER_BYTE);
    assign w_is_bs    = (w_b0 == BS_BYTE);
    assign w_key      = w_is_esc ? match_key(w_cut) : KEY_NONE;
    assign w_insert   = (w_b0 > PRINT_MIN) && !w_is_bs && (r_cursor < r_wm1);
    assign w_held_p1  = {1'b0, r_held} + (LW+1)'(1);
    assign w_wm1_ext  = {1'b0, r_wm1};
    assign w_newlen   = (w_held_p1 > w_wm1_ext) ? r_wm1 : LW'(w_held_p1);
    assign w_n        = (7'(r_held) > 7'(RESULT_LIMIT)) ? 6'(RESULT_LIMIT) : 6'(r_held);

    always_comb begin
        w_ctrl.op  = OP_HOLD;
        w_ctrl.pos = POS_W'(r_cursor);
        if (r_state == S_DECODE) begin
            if (w_is_esc) begin
                if ((w_key == KEY_DEL) && (r_cursor < r_held)) begin
                    w_ctrl.op = OP_REMOVE;
                end
            end else if (w_is_bs) begin
                if (r_cursor != '0) begin
                    w_ctrl.op  = OP_REMOVE;
                    w_ctrl.pos = POS_W'(r_cursor - LW'(1));
                end
            end else if (!w_is_enter && w_insert) begin
                w_ctrl.op = OP_INSERT;
            end
        end else if (r_state == S_EMIT) begin
            w_ctrl.op = OP_SHIFT;
        end
    end

    for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_inner_l
            assign w_left[g] = w_slot[g-1];
        end
        if (g == MAX_WIDTH - 1) begin : g_end
            assign w_right[g] = w_slot[g];
        end else begin : g_inner_r
            assign w_right[g] = w_slot[g+1];
        end
        tleb_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_char  (r_bytes),
            .o_slot  (w_slot[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bytes  <= '0;
            r_held   <= '0;
            r_cursor <= '0;
            r_wm1    <= f_wm1(6'd32);
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_status <= ST_EDIT;
            r_key    <= KEY_NONE;
            r_char   <= '0;
            r_last   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_wm1 <= f_wm1(i_cfg_line_width);
            end
            unique case (r_state)
                S_IDLE: begin
                    r_strobe <= 1'b0;
                    if (start) begin
                        r_bytes <= {i_byte_7, i_byte_6, i_byte_5, i_byte_4,
                                    i_byte_3, i_byte_2, i_byte_1, i_byte_0};
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_key  <= w_key;
                    r_char <= '0;
                    r_last <= 1'b1;
                    if (w_is_enter) begin
                        r_held   <= '0;
                        r_cursor <= '0;
                        r_status <= ST_ACCEPT;
                        if (w_n != '0) begin
                            r_strobe <= 1'b0;
                            r_count  <= w_n;
                            r_state  <= S_EMIT;
                        end else begin
                            r_strobe <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                    end else begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                        if (w_is_esc && (w_key == KEY_ESC)) begin
                            r_held   <= '0;
                            r_cursor <= '0;
                            r_status <= ST_CANCEL;
                        end else begin
                            r_status <= ST_EDIT;
                            if (w_is_esc) begin
                                if (w_key == KEY_LEFT) begin
                                    if (r_cursor != '0) begin
                                        r_cursor <= r_cursor - LW'(1);
                                    end
                                end else if (w_key == KEY_RIGHT) begin
                                    if (r_cursor < r_held) begin
                                        r_cursor <= r_cursor + LW'(1);
                                    end
                                end else if (w_key == KEY_DEL) begin
                                    if (r_cursor < r_held) begin
                                        r_held <= r_held - LW'(1);
                                    end
                                end
                            end else if (w_is_bs) begin
                                if (r_cursor != '0) begin
                                    r_cursor <= r_cursor - LW'(1);
                                    r_held   <= r_held - LW'(1);
                                end
                            end else if (w_insert) begin
                                r_held   <= w_newlen;
                                r_cursor <= r_cursor + LW'(1);
                            end
                        end
                    end
                end
                S_EMIT: begin
                    r_strobe <= 1'b1;
                    r_status <= ST_ACCEPT;
                    r_key    <= KEY_NONE;
                    r_char   <= w_slot[0];
                    r_last   <= (r_count == 6'd1);
                    r_count  <= r_count - 6'd1;
                    if (r_count == 6'd1) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_strobe <= 1'b0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_key_id      = r_key;
    assign o_cursor_pos  = 5'(r_cursor);
    assign o_line_length = 5'(r_held);
    assign o_char_data   = r_char;
    assign o_last        = r_last;

endmodule

>>> design/tleb_checker.sv
// Port level checks of the line edit buffer and their binding to the top level.
module tleb_port_checks import tleb_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_strobe,
    input logic [1:0]  o_status,
    input logic [4:0]  o_cursor_pos,
    input logic [4:0]  o_line_length,
    input logic [63:0] o_char_data,
    input logic        o_last
);

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("Result word without a word in progress.");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != ST_ACCEPT)) |-> o_last)
        else $error("Edit or cancel result is not the final word.");

    a_cancel_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_CANCEL)) |->
            ((o_line_length == 5'd0) && (o_cursor_pos == 5'd0)))
        else $error("Cancel left characters in the line.");

    a_edit_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_EDIT)) |-> (o_char_data == 64'd0))
        else $error("Edit result carries character data.");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("Block still busy on the final result.");

endmodule

bind terminal_line_edit_buffer_core tleb_port_checks u_tleb_port_checks (.*);
